@@ sv/qfs_pkg.sv @@
// Shared types and character codes for the quoted field splitter.
package qfs_pkg;

  // Request arriving on the input channel: one byte of text, or an end-of-input mark
  typedef struct packed {
    logic [7:0] char_in;
    logic       at_end;
  } in_item_t;

  // Request leaving on the output channel: one token mark or field byte
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FEND = 2'd1;
  localparam logic [1:0] KIND_LEND = 2'd2;
  localparam logic [1:0] KIND_EOI  = 2'd3;

  // Open quote codes
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_LC_B   = 8'h62;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;
  localparam logic [7:0] CHAR_LC_N   = 8'h6E;
  localparam logic [7:0] CHAR_LC_R   = 8'h72;
  localparam logic [7:0] CHAR_LC_T   = 8'h74;
  localparam logic [7:0] CHAR_LC_V   = 8'h76;

  // Control codes produced by letter escapes
  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0C;
  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_HT = 8'h09;
  localparam logic [7:0] CODE_VT = 8'h0B;

endpackage

@@ sv/quoted_field_splitter.sv @@
// The results of a taken request are written into the result queue and offered from there.
// Throughput: one input request per cycle while the eight-entry result queue has room
// for four more results; results leave at one per cycle while not stalled, so a byte giving
// several results holds the input back once the queue fills. The output rate sets the sustained rate.
// Reset (asynchronous, active low) returns the tokenizer to line start and empties
// the result queue at once; no clearing pass is needed.
module quoted_field_splitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qfs_pkg::in_item_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qfs_pkg::out_item_t  out_req_o
);
  import qfs_pkg::*;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned MaxRes     = 4;

  typedef enum logic [2:0] {
    MODE_LINE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_GAP     = 3'd2,
    MODE_FIELD   = 3'd3,
    MODE_ESC     = 3'd4,
    MODE_OCT     = 3'd5
  } mode_e;

  // Outcome of one byte handled in field context
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] k0;
    logic [1:0] k1;
    logic [7:0] v0;
    mode_e      mode;
    logic [1:0] oq;
  } fc_t;

  function automatic fc_t field_char(input logic [7:0] c, input logic [1:0] oq);
    fc_t        r;
    logic [1:0] q;
    q = (c == CHAR_SQUOTE) ? QUOTE_SINGLE :
        (c == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_NONE;
    r.cnt  = 2'd0;
    r.k0   = KIND_BYTE;
    r.k1   = KIND_BYTE;
    r.v0   = 8'h00;
    r.mode = MODE_FIELD;
    r.oq   = oq;
    if (c == CHAR_NL) begin
      r.cnt  = 2'd2;
      r.k0   = KIND_FEND;
      r.k1   = KIND_LEND;
      r.mode = MODE_LINE;
    end else if ((c == CHAR_SPACE || c == CHAR_TAB) && oq == QUOTE_NONE) begin
      r.cnt  = 2'd1;
      r.k0   = KIND_FEND;
      r.mode = MODE_GAP;
    end else if (c == CHAR_BSLASH) begin
      r.mode = MODE_ESC;
    end else if (q != QUOTE_NONE && oq == QUOTE_NONE) begin
      r.oq = q;
    end else if (q != QUOTE_NONE && oq == q) begin
      r.oq = QUOTE_NONE;
    end else begin
      r.cnt = 2'd1;
      r.v0  = c;
    end
    return r;
  endfunction

  // Tokenizer state
  mode_e      mode_q, mode_d;
  logic [1:0] oq_q, oq_d;
  logic [7:0] ov_q, ov_d;
  logic [1:0] od_q, od_d;

  // Result queue
  out_item_t         queue_q [QueueDepth];
  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [PtrW:0]     count_q, count_d;

  logic              accept, pop;
  logic [7:0]        c;
  logic              pre_en, fc_en, do_gap;
  logic [1:0]        pre_kind, fc_oq;
  logic [7:0]        pre_val;
  logic [7:0]        ov_next;
  logic [1:0]        od_next;
  fc_t               fc;
  logic [1:0]        res_kind [MaxRes];
  logic [7:0]        res_val  [MaxRes];
  logic [2:0]        n_res;

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;
  assign c      = in_req_i.char_in;

  // Room for a worst-case burst of four results
  assign in_stall_o  = count_q > (PtrW+1)'(QueueDepth - MaxRes);
  assign out_valid_o = count_q != '0;
  assign out_req_o   = queue_q[rp_q];

  // Per-byte decode: an optional leading result, then the field handler
  always_comb begin
    mode_d   = mode_q;
    oq_d     = oq_q;
    ov_d     = ov_q;
    od_d     = od_q;
    pre_en   = 1'b0;
    pre_kind = KIND_BYTE;
    pre_val  = 8'h00;
    fc_en    = 1'b0;
    fc_oq    = oq_q;
    fc       = '0;
    do_gap   = 1'b0;
    ov_next  = {ov_q[4:0], 3'b000} + {5'b0, c[2:0]};
    od_next  = od_q + 2'd1;
    n_res    = 3'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res_kind[i] = KIND_BYTE;
      res_val[i]  = 8'h00;
    end

    if (in_req_i.at_end) begin
      // End of input flushes whatever is open, then resets the state
      if (mode_q == MODE_ESC) begin
        res_val[n_res[1:0]] = CHAR_BSLASH;
        n_res = n_res + 3'd1;
      end
      if (mode_q == MODE_OCT) begin
        res_val[n_res[1:0]] = ov_q;
        n_res = n_res + 3'd1;
      end
      if (mode_q == MODE_FIELD || mode_q == MODE_ESC || mode_q == MODE_OCT) begin
        res_kind[n_res[1:0]] = KIND_FEND;
        n_res = n_res + 3'd1;
      end
      if (mode_q == MODE_GAP || mode_q == MODE_FIELD || mode_q == MODE_ESC ||
          mode_q == MODE_OCT) begin
        res_kind[n_res[1:0]] = KIND_LEND;
        n_res = n_res + 3'd1;
      end
      res_kind[n_res[1:0]] = KIND_EOI;
      n_res = n_res + 3'd1;
      mode_d = MODE_LINE;
      oq_d   = QUOTE_NONE;
      ov_d   = 8'h00;
      od_d   = 2'd0;
    end else begin
      case (mode_q)
        MODE_COMMENT: begin
          if (c == CHAR_NL) mode_d = MODE_LINE;
        end
        MODE_GAP: begin
          do_gap = 1'b1;
        end
        MODE_FIELD: begin
          fc_en = 1'b1;
        end
        MODE_ESC: begin
          mode_d = MODE_FIELD;
          case (c) inside
            CHAR_LC_B: begin pre_en = 1'b1; pre_val = CODE_BS; end
            CHAR_LC_F: begin pre_en = 1'b1; pre_val = CODE_FF; end
            CHAR_LC_N: begin pre_en = 1'b1; pre_val = CODE_LF; end
            CHAR_LC_R: begin pre_en = 1'b1; pre_val = CODE_CR; end
            CHAR_LC_T: begin pre_en = 1'b1; pre_val = CODE_HT; end
            CHAR_LC_V: begin pre_en = 1'b1; pre_val = CODE_VT; end
            CHAR_SQUOTE, CHAR_DQUOTE, CHAR_HASH, CHAR_SPACE, CHAR_TAB,
            CHAR_BSLASH: begin
              pre_en  = 1'b1;
              pre_val = c;
            end
            CHAR_NL: begin
              // line continuation: nothing produced
            end
            [CHAR_ZERO:CHAR_SEVEN]: begin
              ov_d   = {5'b0, c[2:0]};
              od_d   = 2'd1;
              mode_d = MODE_OCT;
            end
            default: begin
              // unknown escape keeps the backslash
              pre_en  = 1'b1;
              pre_val = CHAR_BSLASH;
              fc_en   = 1'b1;
            end
          endcase
        end
        MODE_OCT: begin
          if (c inside {[CHAR_ZERO:CHAR_SEVEN]}) begin
            if (od_next == 2'd3) begin
              pre_en  = 1'b1;
              pre_val = ov_next;
              ov_d    = 8'h00;
              od_d    = 2'd0;
              mode_d  = MODE_FIELD;
            end else begin
              ov_d = ov_next;
              od_d = od_next;
            end
          end else begin
            pre_en  = 1'b1;
            pre_val = ov_q;
            ov_d    = 8'h00;
            od_d    = 2'd0;
            mode_d  = MODE_FIELD;
            fc_en   = 1'b1;
          end
        end
        default: begin
          // line start, and any unused code
          if (c == CHAR_HASH) mode_d = MODE_COMMENT;
          else do_gap = 1'b1;
        end
      endcase

      // Between fields: blanks skipped, newline ends the line, else a field opens
      if (do_gap) begin
        if (c == CHAR_NL) begin
          pre_en   = 1'b1;
          pre_kind = KIND_LEND;
          mode_d   = MODE_LINE;
        end else if (c != CHAR_SPACE && c != CHAR_TAB) begin
          fc_oq = QUOTE_NONE;
          fc_en = 1'b1;
        end
      end

      fc = field_char(c, fc_oq);
      if (fc_en) begin
        mode_d = fc.mode;
        oq_d   = fc.oq;
      end

      // Assemble the result list
      if (pre_en) begin
        res_kind[0] = pre_kind;
        res_val[0]  = pre_val;
        n_res       = 3'd1;
      end
      if (fc_en && fc.cnt != 2'd0) begin
        res_kind[n_res[1:0]] = fc.k0;
        res_val[n_res[1:0]]  = fc.v0;
        n_res = n_res + 3'd1;
      end
      if (fc_en && fc.cnt == 2'd2) begin
        res_kind[n_res[1:0]] = fc.k1;
        n_res = n_res + 3'd1;
      end
    end
  end

  // Pointer and fill-level update
  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    count_d = count_q;
    if (accept) begin
      wp_d    = wp_q + PtrW'(n_res);
      count_d = count_d + (PtrW+1)'(n_res);
    end
    if (pop) begin
      rp_d    = rp_q + PtrW'(1);
      count_d = count_d - (PtrW+1)'(1);
    end
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINE;
      oq_q    <= QUOTE_NONE;
      ov_q    <= 8'h00;
      od_q    <= 2'd0;
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        oq_q   <= oq_d;
        ov_q   <= ov_d;
        od_q   <= od_d;
      end
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  // Queue storage: write the burst of results at consecutive slots
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (3'(i) < n_res) begin
          queue_q[wp_q + PtrW'(i)] <= '{kind:  res_kind[i],
                                        value: res_val[i],
                                        last:  (3'(i) == n_res - 3'd1)};
        end
      end
    end
  end

endmodule

@@ sv/qfs_checker.sv @@
// Port-level assertions for the quoted field splitter, bound to the top level.
module qfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input qfs_pkg::in_item_t   in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input qfs_pkg::out_item_t  out_req_o
);
  import qfs_pkg::*;

  // An accepted end of input always yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.at_end |=> out_valid_o)
    else $error("end of input gave no result");

  // End of input mark always closes the burst of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.kind == KIND_EOI |-> out_req_o.last)
    else $error("end of input mark without last");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_req_o))
    else $error("result changed while stalled");

endmodule

bind quoted_field_splitter qfs_checker u_qfs_checker (.*);

@@ test/quoted_field_splitter_tb.sv @@
// Self-checking testbench for the quoted field splitter: line, quote and escape tokenizing.
`timescale 1ns / 1ps

module quoted_field_splitter_tb;
  import qfs_pkg::*;

  localparam int         RUN_LIMIT  = 500000;
  localparam int         TAIL_WAIT  = 20;
  localparam int         RAND_ITEMS = 500;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;

  // Tokenizer states of the predictor
  typedef enum logic [2:0] {
    ST_LINE, ST_COMMENT, ST_GAP, ST_FIELD, ST_ESC, ST_OCT
  } tok_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_req_i    = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_req_o;

  quoted_field_splitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t  byte_q[$];    // bytes still to be sent
  out_item_t token_q[$];   // tokens the splitter owes us
  out_item_t step_q[$];    // tokens of the request being predicted

  tok_mode_e  tok_mode  = ST_LINE;
  logic [1:0] tok_quote = QUOTE_NONE;
  logic [7:0] oct_val   = 8'h00;
  logic [1:0] oct_cnt   = 2'd0;

  int n_sent     = 0;
  int n_total    = 0;
  int n_directed = 0;
  int n_ends     = 0;
  int n_checked  = 0;
  int n_lines    = 0;
  int err_cnt    = 0;
  int cyc_cnt    = 0;
  int tx_hold    = 0;
  int rx_hold    = 0;
  logic quiet;

  out_item_t mon_got;
  out_item_t mon_want;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic void put_token(logic [1:0] kind, logic [7:0] val);
    out_item_t r;
    if (step_q.size() < 4) begin
      r.kind  = kind;
      r.value = (kind == KIND_BYTE) ? val : 8'h00;
      r.last  = 1'b0;
      step_q.push_back(r);
    end
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

  // Byte inside a field
  function automatic void field_byte(logic [7:0] c);
    logic [1:0] q;
    q = (c == CHAR_SQUOTE) ? QUOTE_SINGLE : (c == CHAR_DQUOTE) ? QUOTE_DOUBLE : QUOTE_NONE;
    if (c == CHAR_NL) begin
      // newline closes field and line, quotes or not
      put_token(KIND_FEND, 8'h00);
      put_token(KIND_LEND, 8'h00);
      tok_mode = ST_LINE;
    end else if (is_blank(c) && tok_quote == QUOTE_NONE) begin
      put_token(KIND_FEND, 8'h00);
      tok_mode = ST_GAP;
    end else if (c == CHAR_BSLASH) begin
      tok_mode = ST_ESC;
    end else if (q != QUOTE_NONE && tok_quote == QUOTE_NONE) begin
      tok_quote = q;
    end else if (q != QUOTE_NONE && tok_quote == q) begin
      tok_quote = QUOTE_NONE;
    end else begin
      put_token(KIND_BYTE, c);
    end
  endfunction

  // Byte between fields; a non-blank opens a new field with quotes cleared
  function automatic void gap_byte(logic [7:0] c);
    if (c == CHAR_NL) begin
      put_token(KIND_LEND, 8'h00);
      tok_mode = ST_LINE;
    end else if (!is_blank(c)) begin
      tok_quote = QUOTE_NONE;
      tok_mode  = ST_FIELD;
      field_byte(c);
    end
  endfunction

  // Byte after a backslash
  function automatic void esc_byte(logic [7:0] c);
    tok_mode = ST_FIELD;
    if (is_octal(c)) begin
      oct_val  = c - CHAR_ZERO;
      oct_cnt  = 2'd1;
      tok_mode = ST_OCT;
    end else if (c != CHAR_NL) begin
      case (c)
        CHAR_LC_B: put_token(KIND_BYTE, CODE_BS);
        CHAR_LC_F: put_token(KIND_BYTE, CODE_FF);
        CHAR_LC_N: put_token(KIND_BYTE, CODE_LF);
        CHAR_LC_R: put_token(KIND_BYTE, CODE_CR);
        CHAR_LC_T: put_token(KIND_BYTE, CODE_HT);
        CHAR_LC_V: put_token(KIND_BYTE, CODE_VT);
        CHAR_SQUOTE, CHAR_DQUOTE, CHAR_HASH, CHAR_SPACE, CHAR_TAB, CHAR_BSLASH:
          put_token(KIND_BYTE, c);
        default: begin
          // unknown escape keeps its backslash
          put_token(KIND_BYTE, CHAR_BSLASH);
          field_byte(c);
        end
      endcase
    end
  endfunction

  // Byte inside an octal escape; three digits or a non-digit close it
  function automatic void oct_byte(logic [7:0] c);
    if (is_octal(c)) begin
      oct_val = {oct_val[4:0], 3'b000} + (c - CHAR_ZERO);
      oct_cnt = oct_cnt + 2'd1;
      if (oct_cnt == 2'd3) begin
        put_token(KIND_BYTE, oct_val);
        oct_val  = 8'h00;
        oct_cnt  = 2'd0;
        tok_mode = ST_FIELD;
      end
    end else begin
      put_token(KIND_BYTE, oct_val);
      oct_val  = 8'h00;
      oct_cnt  = 2'd0;
      tok_mode = ST_FIELD;
      field_byte(c);
    end
  endfunction

  // Work out the tokens of one accepted request and queue them
  function automatic void predict_tokens(in_item_t it);
    logic [7:0] c;
    logic       in_word;
    c = it.char_in;
    step_q.delete();
    if (it.at_end) begin
      in_word = (tok_mode == ST_FIELD) || (tok_mode == ST_ESC) || (tok_mode == ST_OCT);
      if (tok_mode == ST_ESC) put_token(KIND_BYTE, CHAR_BSLASH);
      if (tok_mode == ST_OCT) put_token(KIND_BYTE, oct_val);
      if (in_word) put_token(KIND_FEND, 8'h00);
      if (in_word || tok_mode == ST_GAP) put_token(KIND_LEND, 8'h00);
      put_token(KIND_EOI, 8'h00);
      tok_mode  = ST_LINE;
      tok_quote = QUOTE_NONE;
      oct_val   = 8'h00;
      oct_cnt   = 2'd0;
    end else begin
      case (tok_mode)
        ST_COMMENT: if (c == CHAR_NL) tok_mode = ST_LINE;
        ST_GAP:     gap_byte(c);
        ST_FIELD:   field_byte(c);
        ST_ESC:     esc_byte(c);
        ST_OCT:     oct_byte(c);
        default: begin
          if (c == CHAR_HASH) tok_mode = ST_COMMENT;
          else gap_byte(c);
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] c);
    in_item_t it;
    it.char_in = c;
    it.at_end  = 1'b0;
    byte_q.push_back(it);
  endtask

  task automatic add_end();
    in_item_t it;
    it.char_in = 8'($urandom_range(0, 255));
    it.at_end  = 1'b1;
    byte_q.push_back(it);
  endtask

  function automatic logic [7:0] plain_char();
    return CHAR_LC_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  // One piece of a well-formed field
  task automatic add_piece();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0, 1, 2: add_byte(plain_char());
      3: begin
        // quoted run, with blanks and the other quote kind inside
        q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
        add_byte(q);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 3))
            0:       add_byte(blank_char());
            1:       add_byte((q == CHAR_SQUOTE) ? CHAR_DQUOTE : CHAR_SQUOTE);
            default: add_byte(plain_char());
          endcase
        end
        if ($urandom_range(0, 7) != 0) add_byte(q);
      end
      4: begin
        add_byte(CHAR_BSLASH);
        case ($urandom_range(0, 5))
          0: add_byte(CHAR_LC_B);
          1: add_byte(CHAR_LC_F);
          2: add_byte(CHAR_LC_N);
          3: add_byte(CHAR_LC_R);
          4: add_byte(CHAR_LC_T);
          default: add_byte(CHAR_LC_V);
        endcase
      end
      5: begin
        add_byte(CHAR_BSLASH);
        case ($urandom_range(0, 5))
          0: add_byte(CHAR_SQUOTE);
          1: add_byte(CHAR_DQUOTE);
          2: add_byte(CHAR_HASH);
          3: add_byte(CHAR_SPACE);
          4: add_byte(CHAR_TAB);
          default: add_byte(CHAR_BSLASH);
        endcase
      end
      6: begin
        // line continuation
        add_byte(CHAR_BSLASH);
        add_byte(CHAR_NL);
      end
      7: begin
        add_byte(CHAR_BSLASH);
        repeat ($urandom_range(1, 3)) add_byte(CHAR_ZERO + 8'($urandom_range(0, 7)));
      end
      8: begin
        add_byte(CHAR_BSLASH);
        add_byte(CHAR_UC_A + 8'($urandom_range(0, 25)));
      end
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  // One line: comment, noise, or blank-separated fields
  task automatic add_line();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      add_byte(CHAR_HASH);
      repeat ($urandom_range(0, 6)) add_byte(plain_char());
      add_byte(CHAR_NL);
    end else if (r <= 2) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 15) == 0) add_end();
        else add_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 2)) add_byte(blank_char());
      repeat ($urandom_range(0, 4)) begin
        repeat ($urandom_range(1, 5)) add_piece();
        repeat ($urandom_range(1, 3)) add_byte(blank_char());
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) add_piece();
      if ($urandom_range(0, 14) == 0) add_end();
      else add_byte(CHAR_NL);
    end
  endtask

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  // No idling near the end, and in quiet stretches along the way
  assign quiet = (n_sent >= n_total - 80) || ((n_sent % 100) > 70);

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_hold    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_tokens(in_req_i);
        if (in_req_i.at_end) n_ends++;
        void'(byte_q.pop_front());
        n_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled request holds
      end else if (tx_hold != 0) begin
        tx_hold    <= tx_hold - 1;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() == 0 ||
                   ((n_sent == n_directed || n_sent == n_total / 2) && token_q.size() != 0)) begin
        // nothing left, or draining at a checkpoint
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        tx_hold    <= $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_req_i   <= byte_q[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        mon_got = out_req_o;
        if (token_q.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d value %02h last %0d",
                               mon_got.kind, mon_got.value, mon_got.last));
        end else begin
          mon_want = token_q.pop_front();
          n_checked++;
          if (mon_want.kind == KIND_LEND) n_lines++;
          if (mon_got.kind !== mon_want.kind || mon_got.value !== mon_want.value ||
              mon_got.last !== mon_want.last) begin
            flag_error($sformatf({"result %0d: expected kind %0d value %02h last %0d, ",
                                  "got kind %0d value %02h last %0d"}, n_checked,
                                 mon_want.kind, mon_want.value, mon_want.last,
                                 mon_got.kind, mon_got.value, mon_got.last));
          end
        end
      end
      if (rx_hold != 0) begin
        rx_hold     <= rx_hold - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rx_hold     <= $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // end in comment, then empty and blank lines
    add_byte(CHAR_HASH); add_byte(CHAR_LC_A); add_end();
    add_byte(CHAR_NL);
    add_byte(CHAR_SPACE); add_byte(CHAR_TAB); add_byte(CHAR_NL);
    // empty quotes, ended in field
    add_byte(CHAR_SQUOTE); add_byte(CHAR_SQUOTE); add_end();
    // end after backslash and in an octal escape
    add_byte(CHAR_LC_A); add_byte(CHAR_BSLASH); add_end();
    add_byte(CHAR_BSLASH); add_byte(CHAR_SEVEN); add_end();
    // extreme bytes, end between fields, end at line start
    add_byte(8'hFF); add_byte(8'h00); add_byte(CHAR_SPACE); add_end();
    add_end();
    // newline inside an open quote
    add_byte(CHAR_DQUOTE); add_byte(CHAR_LC_A); add_byte(CHAR_NL);
    n_directed = byte_q.size();

    while (byte_q.size() < n_directed + RAND_ITEMS) add_line();
    n_total = byte_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent != n_total) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Fed %0d bytes including %0d end-of-input marks (%0d directed).",
             n_total, n_ends, n_directed);
    $display("Checked %0d tokens over %0d lines, %0d errors.", n_checked, n_lines, err_cnt);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ quoted_field_splitter.f @@
sv/qfs_pkg.sv
sv/quoted_field_splitter.sv
sv/qfs_checker.sv
test/quoted_field_splitter_tb.sv
